### rtl/kpd_pkg.sv
// kpd_pkg: shared types and constants of the scanned keypad debouncer
// item structs, field widths and parameter defaults; no dependencies

package kpd_pkg;

    localparam int ROW_COUNT_DEF    = 10;
    localparam int COLUMN_COUNT_DEF = 2;
    localparam int CNT_W            = 3;
    localparam int ROW_W            = 4;
    localparam int EVENT_W          = 2;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 3'd4;

    typedef struct packed {
        logic column_zero_level;
        logic column_one_level;
    } in_item_t;

    typedef struct packed {
        logic [ROW_W-1:0]   scanned_row;
        logic [EVENT_W-1:0] press_events;
        logic [EVENT_W-1:0] release_events;
        logic               row_wrap;
    } out_item_t;

endpackage

### rtl/kpd_row_store.sv
// kpd_row_store: per-row key state memory, one read and one write port
// registered read with write-to-read forwarding and a valid bit per row
// depends on nothing

module kpd_row_store #(
    parameter int DEPTH  = 10,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] mem_q_reg;
    logic [DATA_W-1:0] fwd_data_reg;
    logic              fwd_reg;
    logic              hit_valid_reg;
    logic              same_addr;

    assign same_addr = wr_en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            fwd_reg       <= 1'b0;
            hit_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                fwd_reg       <= same_addr;
                hit_valid_reg <= same_addr || valid_reg[rd_addr];
            end
        end
    end

    // unwritten rows read as released keys with cleared counters
    assign rd_data = !hit_valid_reg ? '0 : (fwd_reg ? fwd_data_reg : mem_q_reg);

endmodule

### rtl/scanned_keypad_debouncer.sv
// scanned_keypad_debouncer: top level of the scanned keypad debouncer
// integrating debounce of one driven row per item; uses kpd_pkg and kpd_row_store
//
// One item is one poll tick with the column levels of the row driven now. The block
// accepts one item per clock cycle while the output is not stalled. The accepting cycle
// reads the row's counters and pressed flags from the row memory; the next stage then
// updates all columns of that row in parallel and, unless stalled, writes them back and
// loads the output register. A row written back is forwarded to a read of the same row
// in that cycle. Every row has a valid bit cleared by reset, so no clearing pass is
// needed. The threshold register may be written only while the block is idle.

module scanned_keypad_debouncer #(
    parameter int ROW_COUNT    = kpd_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kpd_pkg::COLUMN_COUNT_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  kpd_pkg::in_item_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output kpd_pkg::out_item_t       m_data,
    input  logic                     cfg_we,
    input  logic [kpd_pkg::CNT_W-1:0] cfg_wdata
);

    import kpd_pkg::*;

    localparam int ADDR_W  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int ENTRY_W = COLUMN_COUNT * (CNT_W + 1);
    localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(ROW_COUNT - 1);

    logic [CNT_W-1:0]  threshold_reg;
    logic [ADDR_W-1:0] row_reg, row_next;
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_row_reg;
    in_item_t          s1_item_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg, m_data_next;
    logic              accept, advance, wrap;

    logic [ENTRY_W-1:0] rd_entry, wr_entry;
    logic [COLUMN_COUNT-1:0][CNT_W-1:0] cnt_old, cnt_new;
    logic [COLUMN_COUNT-1:0] flag_old, flag_new, level, press_all, release_all;
    logic [EVENT_W-1:0] press_ev, release_ev;

    assign advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !s1_valid_reg || advance;
    assign accept  = s_valid && s_ready;
    assign wrap    = (s1_row_reg == LAST_ROW);
    assign row_next = (row_reg == LAST_ROW) ? '0 : row_reg + 1'b1;

    kpd_row_store #(
        .DEPTH  (ROW_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (row_reg),
        .rd_data (rd_entry),
        .wr_en   (advance),
        .wr_addr (s1_row_reg),
        .wr_data (wr_entry)
    );

    assign {flag_old, cnt_old} = rd_entry;
    assign wr_entry = {flag_new, cnt_new};

    always_comb begin
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            if (c == 0) begin
                level[c] = s1_item_reg.column_zero_level;
            end else if (c == 1) begin
                level[c] = s1_item_reg.column_one_level;
            end else begin
                level[c] = 1'b0;
            end
            cnt_new[c] = cnt_old[c];
            if (level[c]) begin
                if (cnt_old[c] < threshold_reg) begin
                    cnt_new[c] = cnt_old[c] + 1'b1;
                end
            end else if (cnt_old[c] != '0) begin
                cnt_new[c] = cnt_old[c] - 1'b1;
            end
            flag_new[c]    = flag_old[c];
            press_all[c]   = 1'b0;
            release_all[c] = 1'b0;
            if (cnt_new[c] == threshold_reg) begin
                if (!flag_old[c]) begin
                    flag_new[c]  = 1'b1;
                    press_all[c] = 1'b1;
                end
            end else if (cnt_new[c] == '0) begin
                if (flag_old[c]) begin
                    flag_new[c]    = 1'b0;
                    release_all[c] = 1'b1;
                end
            end
        end
    end

    for (genvar e = 0; e < EVENT_W; e++) begin : g_event
        if (e < COLUMN_COUNT) begin : g_col
            assign press_ev[e]   = press_all[e];
            assign release_ev[e] = release_all[e];
        end else begin : g_none
            assign press_ev[e]   = 1'b0;
            assign release_ev[e] = 1'b0;
        end
    end

    always_comb begin
        m_data_next.scanned_row    = ROW_W'(s1_row_reg);
        m_data_next.press_events   = press_ev;
        m_data_next.release_events = release_ev;
        m_data_next.row_wrap       = wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= THRESHOLD_RESET;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                threshold_reg <= cfg_wdata;
            end
            if (accept) begin
                row_reg <= row_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_row_reg  <= row_reg;
            s1_item_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
